// ----- hdl/tbec_pkg.sv -----
// shared types and constants for the triangular band energy and correlation block
`timescale 1ns / 1ps
`default_nettype none

package tbec_pkg;

    localparam int NUM_BANDS   = 18;
    localparam int BAND_W      = 5;
    localparam int SAMPLE_W    = 24;
    localparam int WEIGHT_W    = 17;
    localparam int SUM_W       = 56;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified bin on its way from the front to the back
    typedef struct packed {
        logic                       restart;
        logic                       close;
        logic                       last;
        logic [BAND_W-1:0]          band;
        logic [WEIGHT_W-1:0]        wn;
        logic [WEIGHT_W-1:0]        wc;
        logic signed [SAMPLE_W-1:0] xr;
        logic signed [SAMPLE_W-1:0] xi;
        logic signed [SAMPLE_W-1:0] pr;
        logic signed [SAMPLE_W-1:0] pi;
    } entry_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

`default_nettype wire

// ----- hdl/triangular_band_energy_corr.sv -----
// top level of the triangular band energy and correlation block
// a band result passes from the request queue through the product, weighting and emit registers into the result buffer
// throughput: one bin request per cycle while the request queue is not full and the result buffer has room for two
// the bin that closes the band below the top band gives two results, written to the result buffer in the same cycle
// reset clears band and offset counters, all band sums, the request queue and result buffer
`timescale 1ns / 1ps
`default_nettype none

module triangular_band_energy_corr #(
    parameter int BAND_SHIFT  = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 item_valid,
    output logic                                      item_stall,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] x_real,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] x_imag,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] p_real,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] p_imag,
    input  wire logic                                 first_bin,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic [tbec_pkg::BAND_W-1:0]               band,
    output logic [tbec_pkg::SUM_W-1:0]                energy_x,
    output logic [tbec_pkg::SUM_W-1:0]                energy_p,
    output logic signed [tbec_pkg::SUM_W-1:0]         correlation,
    output logic                                      last_band
);
    import tbec_pkg::*;

    q_status_t q_status;
    entry_t    wr_entry;
    entry_t    head;
    logic      push;
    logic      pop;

    tbec_front #(
        .BAND_SHIFT  (BAND_SHIFT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .x_real     (x_real),
        .x_imag     (x_imag),
        .p_real     (p_real),
        .p_imag     (p_imag),
        .first_bin  (first_bin),
        .q_status   (q_status),
        .push       (push),
        .entry      (wr_entry)
    );

    tbec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .status   (q_status),
        .head     (head)
    );

    tbec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .band         (band),
        .energy_x     (energy_x),
        .energy_p     (energy_p),
        .correlation  (correlation),
        .last_band    (last_band)
    );

endmodule

`default_nettype wire

// ----- hdl/tbec_front.sv -----
// front end: band and offset tracking, weight lookup, sample sign extension
`timescale 1ns / 1ps
`default_nettype none

module tbec_front #(
    parameter int BAND_SHIFT  = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] x_real,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] x_imag,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] p_real,
    input  wire logic signed [tbec_pkg::SAMPLE_W-1:0] p_imag,
    input  wire logic                                first_bin,
    input  wire tbec_pkg::q_status_t                 q_status,
    output logic                                     push,
    output tbec_pkg::entry_t                         entry
);
    import tbec_pkg::*;

    localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(65536);

    function automatic logic [2:0] band_width(input logic [BAND_W-1:0] b);
        logic [2:0] w;
        begin
            case (b) inside
                [5'd0:5'd7]:   w = 3'd1;
                [5'd8:5'd11]:  w = 3'd2;
                [5'd12:5'd14]: w = 3'd4;
                default:       w = 3'd6;
            endcase
            return w;
        end
    endfunction

    // floor(65536 / width) for the band, before the band shift
    function automatic logic [WEIGHT_W-1:0] recip_base(input logic [BAND_W-1:0] b);
        logic [WEIGHT_W-1:0] r;
        begin
            case (b) inside
                [5'd0:5'd7]:   r = WEIGHT_W'(65536);
                [5'd8:5'd11]:  r = WEIGHT_W'(32768);
                [5'd12:5'd14]: r = WEIGHT_W'(16384);
                default:       r = WEIGHT_W'(10922);
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sext(input logic [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_BITS-1:0] s;
        begin
            s = signed'(v[SAMPLE_BITS-1:0]);
            return SAMPLE_W'(s);
        end
    endfunction

    logic [BAND_W-1:0]   band_reg;
    logic [5:0]          offset_reg;
    logic [BAND_W-1:0]   eff_band;
    logic [5:0]          eff_offset;
    logic                accept;
    logic                active;
    logic [6:0]          size;
    logic [6:0]          offset_inc;
    logic                close;
    logic [WEIGHT_W-1:0] recip;
    logic [22:0]         wn_full;
    logic [WEIGHT_W-1:0] wn;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;

    // a new frame starts from band zero, offset zero
    assign eff_band   = first_bin ? '0 : band_reg;
    assign eff_offset = first_bin ? '0 : offset_reg;
    assign active     = eff_band < BAND_W'(NUM_BANDS - 1);

    assign size       = 7'(band_width(eff_band)) << BAND_SHIFT;
    assign recip      = recip_base(eff_band) >> BAND_SHIFT;
    assign wn_full    = 23'(eff_offset) * 23'(recip);
    assign wn         = (wn_full > 23'(W_ONE)) ? W_ONE : wn_full[WEIGHT_W-1:0];
    assign offset_inc = {1'b0, eff_offset} + 7'd1;
    assign close      = offset_inc >= size;

    assign push          = accept && active;
    assign entry.restart = first_bin;
    assign entry.close   = close;
    assign entry.last    = close && (eff_band == BAND_W'(NUM_BANDS - 2));
    assign entry.band    = eff_band;
    assign entry.wn      = wn;
    assign entry.wc      = W_ONE - wn;
    assign entry.xr      = sext(x_real);
    assign entry.xi      = sext(x_imag);
    assign entry.pr      = sext(p_real);
    assign entry.pi      = sext(p_imag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg   <= '0;
            offset_reg <= '0;
        end
        else if (push)
        begin
            if (close)
            begin
                band_reg   <= eff_band + BAND_W'(1);
                offset_reg <= '0;
            end
            else
            begin
                band_reg   <= eff_band;
                offset_reg <= offset_inc[5:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tbec_queue.sv -----
// short request queue between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module tbec_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tbec_pkg::entry_t    wr_entry,
    input  wire logic                pop,
    output tbec_pkg::q_status_t      status,
    output tbec_pkg::entry_t         head
);
    import tbec_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.avail = count_reg != '0;
    assign head         = slot_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.avail;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tbec_back.sv -----
// back end: products, triangular weighting, band accumulators and result buffer
`timescale 1ns / 1ps
`default_nettype none

module tbec_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tbec_pkg::q_status_t              q_status,
    input  wire tbec_pkg::entry_t                 head,
    output logic                                  pop,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic [tbec_pkg::BAND_W-1:0]           band,
    output logic [tbec_pkg::SUM_W-1:0]            energy_x,
    output logic [tbec_pkg::SUM_W-1:0]            energy_p,
    output logic signed [tbec_pkg::SUM_W-1:0]     correlation,
    output logic                                  last_band
);
    import tbec_pkg::*;

    localparam int TE_W    = 2 * SAMPLE_W;
    localparam int TC_W    = 2 * SAMPLE_W + 1;
    localparam int RES_DEPTH = 4;
    localparam int RPTR_W  = $clog2(RES_DEPTH);
    localparam int RCNT_W  = $clog2(RES_DEPTH + 1);

    localparam logic [SUM_W-1:0]        E_MAX = '1;
    localparam logic signed [SUM_W-1:0] C_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] C_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic [BAND_W-1:0]        band;
        logic [SUM_W-1:0]         ex;
        logic [SUM_W-1:0]         ep;
        logic signed [SUM_W-1:0]  c;
        logic                     last;
    } res_t;

    function automatic logic [SUM_W-1:0] sat_e(input logic [SUM_W-1:0] a,
                                              input logic [TE_W-1:0] b);
        logic [SUM_W:0] s;
        begin
            s = {1'b0, a} + (SUM_W+1)'(b);
            return s[SUM_W] ? E_MAX : s[SUM_W-1:0];
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_c(input logic signed [SUM_W-1:0] a,
                                                     input logic signed [TC_W-1:0] b);
        logic signed [SUM_W:0] s;
        begin
            s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
            if (s[SUM_W] != s[SUM_W-1])
            begin
                return s[SUM_W] ? C_MIN : C_MAX;
            end
            return s[SUM_W-1:0];
        end
    endfunction

    function automatic logic [SUM_W-1:0] dbl_e(input logic [SUM_W-1:0] a);
        return a[SUM_W-1] ? E_MAX : {a[SUM_W-2:0], 1'b0};
    endfunction

    function automatic logic signed [SUM_W-1:0] dbl_c(input logic signed [SUM_W-1:0] a);
        logic signed [SUM_W-1:0] r;
        begin
            if (a[SUM_W-1] != a[SUM_W-2])
            begin
                r = a[SUM_W-1] ? C_MIN : C_MAX;
            end
            else
            begin
                r = {a[SUM_W-2:0], 1'b0};
            end
            return r;
        end
    endfunction

    // whole back end moves together while the result buffer has room for two
    logic adv;

    // product stage
    logic                    p_valid_reg;
    logic [TE_W-1:0]         p_tx_reg;
    logic [TE_W-1:0]         p_tp_reg;
    logic signed [TC_W-1:0]  p_tc_reg;
    logic [WEIGHT_W-1:0]     p_wn_reg;
    logic [WEIGHT_W-1:0]     p_wc_reg;
    logic                    p_restart_reg;
    logic                    p_close_reg;
    logic                    p_last_reg;
    logic [BAND_W-1:0]       p_band_reg;

    logic signed [TE_W-1:0]  m_xr;
    logic signed [TE_W-1:0]  m_xi;
    logic signed [TE_W-1:0]  m_pr;
    logic signed [TE_W-1:0]  m_pi;
    logic signed [TE_W-1:0]  m_cr;
    logic signed [TE_W-1:0]  m_ci;
    logic [TE_W-1:0]         tx_next;
    logic [TE_W-1:0]         tp_next;
    logic signed [TC_W-1:0]  tc_next;

    // weighting stage
    logic                    w_valid_reg;
    logic [TE_W-1:0]         w_exc_reg;
    logic [TE_W-1:0]         w_epc_reg;
    logic signed [TC_W-1:0]  w_cc_reg;
    logic [TE_W-1:0]         w_exn_reg;
    logic [TE_W-1:0]         w_epn_reg;
    logic signed [TC_W-1:0]  w_cn_reg;
    logic                    w_restart_reg;
    logic                    w_close_reg;
    logic                    w_last_reg;
    logic [BAND_W-1:0]       w_band_reg;

    logic [TE_W+WEIGHT_W-1:0]         prod_exc;
    logic [TE_W+WEIGHT_W-1:0]         prod_epc;
    logic [TE_W+WEIGHT_W-1:0]         prod_exn;
    logic [TE_W+WEIGHT_W-1:0]         prod_epn;
    logic signed [TC_W+WEIGHT_W:0]    prod_cc;
    logic signed [TC_W+WEIGHT_W:0]    prod_cn;

    // band accumulators
    logic [SUM_W-1:0]         cur_ex_reg;
    logic [SUM_W-1:0]         cur_ep_reg;
    logic signed [SUM_W-1:0]  cur_c_reg;
    logic [SUM_W-1:0]         nxt_ex_reg;
    logic [SUM_W-1:0]         nxt_ep_reg;
    logic signed [SUM_W-1:0]  nxt_c_reg;
    logic [SUM_W-1:0]         base_cur_ex;
    logic [SUM_W-1:0]         base_cur_ep;
    logic signed [SUM_W-1:0]  base_cur_c;
    logic [SUM_W-1:0]         base_nxt_ex;
    logic [SUM_W-1:0]         base_nxt_ep;
    logic signed [SUM_W-1:0]  base_nxt_c;
    logic [SUM_W-1:0]         sum_cur_ex;
    logic [SUM_W-1:0]         sum_cur_ep;
    logic signed [SUM_W-1:0]  sum_cur_c;
    logic [SUM_W-1:0]         sum_nxt_ex;
    logic [SUM_W-1:0]         sum_nxt_ep;
    logic signed [SUM_W-1:0]  sum_nxt_c;

    // emit stage
    logic                     e0_valid_reg;
    logic                     e1_valid_reg;
    logic                     e_dbl_reg;
    logic [BAND_W-1:0]        e_band_reg;
    logic [SUM_W-1:0]         e0_ex_reg;
    logic [SUM_W-1:0]         e0_ep_reg;
    logic signed [SUM_W-1:0]  e0_c_reg;
    logic [SUM_W-1:0]         e1_ex_reg;
    logic [SUM_W-1:0]         e1_ep_reg;
    logic signed [SUM_W-1:0]  e1_c_reg;
    res_t                     res0;
    res_t                     res1;

    // result buffer
    res_t                     res_mem_reg [RES_DEPTH];
    logic [RPTR_W-1:0]        res_wr_reg;
    logic [RPTR_W-1:0]        res_rd_reg;
    logic [RCNT_W-1:0]        res_count_reg;
    logic [RPTR_W-1:0]        res_wr_inc;
    logic                     push0;
    logic                     push1;
    logic                     res_pop;
    res_t                     res_head;

    assign adv = res_count_reg <= RCNT_W'(RES_DEPTH - 2);
    assign pop = adv && q_status.avail;

    // product stage
    assign m_xr    = head.xr * head.xr;
    assign m_xi    = head.xi * head.xi;
    assign m_pr    = head.pr * head.pr;
    assign m_pi    = head.pi * head.pi;
    assign m_cr    = head.xr * head.pr;
    assign m_ci    = head.xi * head.pi;
    assign tx_next = $unsigned(m_xr) + $unsigned(m_xi);
    assign tp_next = $unsigned(m_pr) + $unsigned(m_pi);
    assign tc_next = TC_W'(m_cr) + TC_W'(m_ci);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_tx_reg      <= tx_next;
            p_tp_reg      <= tp_next;
            p_tc_reg      <= tc_next;
            p_wn_reg      <= head.wn;
            p_wc_reg      <= head.wc;
            p_restart_reg <= head.restart;
            p_close_reg   <= head.close;
            p_last_reg    <= head.last;
            p_band_reg    <= head.band;
        end
    end

    // weighting stage, floor of term * w / 65536
    assign prod_exc = (TE_W+WEIGHT_W)'(p_tx_reg) * (TE_W+WEIGHT_W)'(p_wc_reg);
    assign prod_epc = (TE_W+WEIGHT_W)'(p_tp_reg) * (TE_W+WEIGHT_W)'(p_wc_reg);
    assign prod_exn = (TE_W+WEIGHT_W)'(p_tx_reg) * (TE_W+WEIGHT_W)'(p_wn_reg);
    assign prod_epn = (TE_W+WEIGHT_W)'(p_tp_reg) * (TE_W+WEIGHT_W)'(p_wn_reg);
    assign prod_cc  = p_tc_reg * $signed({1'b0, p_wc_reg});
    assign prod_cn  = p_tc_reg * $signed({1'b0, p_wn_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_exc_reg     <= prod_exc[TE_W+15:16];
            w_epc_reg     <= prod_epc[TE_W+15:16];
            w_exn_reg     <= prod_exn[TE_W+15:16];
            w_epn_reg     <= prod_epn[TE_W+15:16];
            w_cc_reg      <= prod_cc[TC_W+15:16];
            w_cn_reg      <= prod_cn[TC_W+15:16];
            w_restart_reg <= p_restart_reg;
            w_close_reg   <= p_close_reg;
            w_last_reg    <= p_last_reg;
            w_band_reg    <= p_band_reg;
        end
    end

    // accumulate, a new frame starts from empty sums
    assign base_cur_ex = w_restart_reg ? '0 : cur_ex_reg;
    assign base_cur_ep = w_restart_reg ? '0 : cur_ep_reg;
    assign base_cur_c  = w_restart_reg ? '0 : cur_c_reg;
    assign base_nxt_ex = w_restart_reg ? '0 : nxt_ex_reg;
    assign base_nxt_ep = w_restart_reg ? '0 : nxt_ep_reg;
    assign base_nxt_c  = w_restart_reg ? '0 : nxt_c_reg;

    assign sum_cur_ex = sat_e(base_cur_ex, w_exc_reg);
    assign sum_cur_ep = sat_e(base_cur_ep, w_epc_reg);
    assign sum_cur_c  = sat_c(base_cur_c, w_cc_reg);
    assign sum_nxt_ex = sat_e(base_nxt_ex, w_exn_reg);
    assign sum_nxt_ep = sat_e(base_nxt_ep, w_epn_reg);
    assign sum_nxt_c  = sat_c(base_nxt_c, w_cn_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            e0_valid_reg <= 1'b0;
            e1_valid_reg <= 1'b0;
            cur_ex_reg   <= '0;
            cur_ep_reg   <= '0;
            cur_c_reg    <= '0;
            nxt_ex_reg   <= '0;
            nxt_ep_reg   <= '0;
            nxt_c_reg    <= '0;
        end
        else if (adv)
        begin
            p_valid_reg  <= q_status.avail;
            w_valid_reg  <= p_valid_reg;
            e0_valid_reg <= w_valid_reg && w_close_reg;
            e1_valid_reg <= w_valid_reg && w_close_reg && w_last_reg;
            if (w_valid_reg)
            begin
                if (w_close_reg)
                begin
                    // band done: the upper triangle becomes the current band
                    cur_ex_reg <= sum_nxt_ex;
                    cur_ep_reg <= sum_nxt_ep;
                    cur_c_reg  <= sum_nxt_c;
                    nxt_ex_reg <= '0;
                    nxt_ep_reg <= '0;
                    nxt_c_reg  <= '0;
                end
                else
                begin
                    cur_ex_reg <= sum_cur_ex;
                    cur_ep_reg <= sum_cur_ep;
                    cur_c_reg  <= sum_cur_c;
                    nxt_ex_reg <= sum_nxt_ex;
                    nxt_ep_reg <= sum_nxt_ep;
                    nxt_c_reg  <= sum_nxt_c;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_band_reg <= w_band_reg;
            e_dbl_reg  <= w_band_reg == '0;
            e0_ex_reg  <= sum_cur_ex;
            e0_ep_reg  <= sum_cur_ep;
            e0_c_reg   <= sum_cur_c;
            e1_ex_reg  <= sum_nxt_ex;
            e1_ep_reg  <= sum_nxt_ep;
            e1_c_reg   <= sum_nxt_c;
        end
    end

    // first band and top band are doubled
    assign res0.band = e_band_reg;
    assign res0.ex   = e_dbl_reg ? dbl_e(e0_ex_reg) : e0_ex_reg;
    assign res0.ep   = e_dbl_reg ? dbl_e(e0_ep_reg) : e0_ep_reg;
    assign res0.c    = e_dbl_reg ? dbl_c(e0_c_reg) : e0_c_reg;
    assign res0.last = 1'b0;
    assign res1.band = BAND_W'(NUM_BANDS - 1);
    assign res1.ex   = dbl_e(e1_ex_reg);
    assign res1.ep   = dbl_e(e1_ep_reg);
    assign res1.c    = dbl_c(e1_c_reg);
    assign res1.last = 1'b1;

    // result buffer
    assign push0      = adv && e0_valid_reg;
    assign push1      = adv && e1_valid_reg;
    assign res_wr_inc = res_wr_reg + RPTR_W'(1);
    assign res_head   = res_mem_reg[res_rd_reg];
    assign res_pop    = result_valid && !result_stall;

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            res_mem_reg[res_wr_reg] <= res0;
        end
        if (push1)
        begin
            res_mem_reg[res_wr_inc] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            res_wr_reg    <= res_wr_reg + RPTR_W'(push0) + RPTR_W'(push1);
            res_rd_reg    <= res_rd_reg + RPTR_W'(res_pop);
            res_count_reg <= res_count_reg + RCNT_W'(push0) + RCNT_W'(push1)
                             - RCNT_W'(res_pop);
        end
    end

    assign result_valid = res_count_reg != '0;
    assign band         = res_head.band;
    assign energy_x     = res_head.ex;
    assign energy_p     = res_head.ep;
    assign correlation  = res_head.c;
    assign last_band    = res_head.last;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for the triangular band energy and correlation block, with band sum predictor
`timescale 1ns / 1ps

module testbench;
    import tbec_pkg::*;

    localparam int BAND_SHIFT = 2;
    localparam int FRAME_BINS = 40 << BAND_SHIFT;
    localparam int ITEM_COUNT = 850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 16;
    localparam logic [63:0] ENERGY_MAX = 64'h00FF_FFFF_FFFF_FFFF;
    localparam longint CORR_MAX = 64'sh007F_FFFF_FFFF_FFFF;
    localparam longint CORR_MIN = -CORR_MAX - 1;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic                       first;
        logic signed [SAMPLE_W-1:0] xr;
        logic signed [SAMPLE_W-1:0] xi;
        logic signed [SAMPLE_W-1:0] pr;
        logic signed [SAMPLE_W-1:0] pi;
    } bin_t;

    typedef struct packed {
        logic [BAND_W-1:0]       band;
        logic [SUM_W-1:0]        ex;
        logic [SUM_W-1:0]        ep;
        logic signed [SUM_W-1:0] corr;
        logic                    last;
    } band_sums_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic signed [SAMPLE_W-1:0] x_real = '0;
    logic signed [SAMPLE_W-1:0] x_imag = '0;
    logic signed [SAMPLE_W-1:0] p_real = '0;
    logic signed [SAMPLE_W-1:0] p_imag = '0;
    logic first_bin = 1'b0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [BAND_W-1:0] band;
    logic [SUM_W-1:0] energy_x;
    logic [SUM_W-1:0] energy_p;
    logic signed [SUM_W-1:0] correlation;
    logic last_band;

    bin_t bins_to_send[$];
    band_sums_t expected_bands[$];
    bin_t on_port;
    int bins_total = 0;
    int bins_accepted = 0;
    int failures = 0;
    int cycle = 0;
    logic steady;

    // predictor state: band being filled, offset in it, sums for it and the one above
    int band_now = 0;
    int offset = 0;
    logic [63:0] cur_x = '0, cur_p = '0, nxt_x = '0, nxt_p = '0;
    longint cur_c = 0, nxt_c = 0;

    triangular_band_energy_corr #(
        .BAND_SHIFT(BAND_SHIFT),
        .SAMPLE_BITS(SAMPLE_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .x_real(x_real),
        .x_imag(x_imag),
        .p_real(p_real),
        .p_imag(p_imag),
        .first_bin(first_bin),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .band(band),
        .energy_x(energy_x),
        .energy_p(energy_p),
        .correlation(correlation),
        .last_band(last_band)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
    end

    assign steady = (cycle >= 300) && (cycle < 700);

    function automatic int band_width(input int idx);
        if (idx < 8)
            return 1;
        else if (idx < 12)
            return 2;
        else if (idx < 15)
            return 4;
        else
            return 6;
    endfunction

    function automatic logic [63:0] add_energy(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        return (r > ENERGY_MAX) ? ENERGY_MAX : r;
    endfunction

    function automatic longint add_corr(input longint a, input longint b);
        longint r;
        r = a + b;
        if (r > CORR_MAX)
            return CORR_MAX;
        if (r < CORR_MIN)
            return CORR_MIN;
        return r;
    endfunction

    function automatic logic [63:0] weigh_energy(input logic [63:0] t, input int unsigned w);
        logic [63:0] p;
        p = t * 64'(w);
        return p >> 16;
    endfunction

    // arithmetic shift gives the floor for negative products
    function automatic longint weigh_corr(input longint t, input int unsigned w);
        longint p;
        if (w >= 65536)
            return t;
        p = t * longint'(w);
        return p >>> 16;
    endfunction

    function automatic band_sums_t band_result(input int idx, input logic [63:0] ex,
                                               input logic [63:0] ep, input longint c,
                                               input logic last);
        band_sums_t r;
        // edge bands are doubled
        if (idx == 0 || last)
        begin
            ex = add_energy(ex, ex);
            ep = add_energy(ep, ep);
            c = add_corr(c, c);
        end
        r.band = idx[BAND_W-1:0];
        r.ex = ex[SUM_W-1:0];
        r.ep = ep[SUM_W-1:0];
        r.corr = c[SUM_W-1:0];
        r.last = last;
        return r;
    endfunction

    task automatic take_bin(input bin_t b);
        longint xr, xi, pr, pi, tc;
        logic [63:0] tx, tp;
        int unsigned span, recip, wn, wc;
        if (b.first)
        begin
            band_now = 0;
            offset = 0;
            cur_x = '0;
            cur_p = '0;
            nxt_x = '0;
            nxt_p = '0;
            cur_c = 0;
            nxt_c = 0;
        end
        // bins past the top edge are dropped
        if (band_now >= NUM_BANDS - 1)
            return;
        span = band_width(band_now) << BAND_SHIFT;
        recip = 65536 / span;
        xr = longint'(b.xr);
        xi = longint'(b.xi);
        pr = longint'(b.pr);
        pi = longint'(b.pi);
        tx = xr * xr + xi * xi;
        tp = pr * pr + pi * pi;
        tc = xr * pr + xi * pi;
        wn = offset * recip;
        if (wn > 65536)
            wn = 65536;
        wc = 65536 - wn;
        cur_x = add_energy(cur_x, weigh_energy(tx, wc));
        cur_p = add_energy(cur_p, weigh_energy(tp, wc));
        cur_c = add_corr(cur_c, weigh_corr(tc, wc));
        nxt_x = add_energy(nxt_x, weigh_energy(tx, wn));
        nxt_p = add_energy(nxt_p, weigh_energy(tp, wn));
        nxt_c = add_corr(nxt_c, weigh_corr(tc, wn));
        offset = (offset + 1) & 63;
        if (offset >= span || offset == 0)
        begin
            expected_bands.push_back(band_result(band_now, cur_x, cur_p, cur_c, 1'b0));
            cur_x = nxt_x;
            cur_p = nxt_p;
            cur_c = nxt_c;
            nxt_x = '0;
            nxt_p = '0;
            nxt_c = 0;
            band_now++;
            offset = 0;
            if (band_now >= NUM_BANDS - 1)
                expected_bands.push_back(band_result(NUM_BANDS - 1, cur_x, cur_p, cur_c, 1'b1));
        end
    endtask

    task automatic queue_bin(input logic first, input logic signed [SAMPLE_W-1:0] xr,
                             input logic signed [SAMPLE_W-1:0] xi,
                             input logic signed [SAMPLE_W-1:0] pr,
                             input logic signed [SAMPLE_W-1:0] pi);
        bin_t b;
        b.first = first;
        b.xr = xr;
        b.xi = xi;
        b.pr = pr;
        b.pi = pi;
        bins_to_send.push_back(b);
        bins_total++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return SAMPLE_W'($urandom_range(511) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            take_bin(on_port);
            bins_accepted++;
        end
        if (rst_n && (!item_valid || !item_stall))
        begin
            if (bins_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                on_port = bins_to_send.pop_front();
                x_real <= on_port.xr;
                x_imag <= on_port.xi;
                p_real <= on_port.pr;
                p_imag <= on_port.pi;
                first_bin <= on_port.first;
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : monitor
        band_sums_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bands.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: band %0d last %b", band, last_band);
            end
            else
            begin
                want = expected_bands.pop_front();
                if (band !== want.band || energy_x !== want.ex || energy_p !== want.ep ||
                    correlation !== want.corr || last_band !== want.last)
                begin
                    failures++;
                    if (failures <= 10)
                    begin
                        $display("mismatch: expected band %0d ex %h ep %h corr %h last %b",
                                 want.band, want.ex, want.ep, want.corr, want.last);
                        $display("          got band %0d ex %h ep %h corr %h last %b",
                                 band, energy_x, energy_p, correlation, last_band);
                    end
                end
            end
        end
        result_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    initial
    begin : stimulus
        int k, length, counted;
        logic broken;
        // no first bin after reset: these count as bin zero onward of band 0
        queue_bin(1'b0, S_MAX, S_MAX, S_MAX, S_MAX);
        queue_bin(1'b0, S_MIN, S_MIN, S_MIN, S_MIN);
        queue_bin(1'b0, S_MAX, S_MIN, S_MIN, S_MAX);
        queue_bin(1'b0, 24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555);
        queue_bin(1'b0, S_MIN, '0, S_MAX, '0);
        queue_bin(1'b0, 24'sd1, -24'sd1, -24'sd1, 24'sd1);
        // restart mid frame, the unfinished band sums of the partial frame are dropped
        queue_bin(1'b1, S_MIN, S_MAX, S_MAX, S_MIN);
        queue_bin(1'b0, '0, '0, '0, '0);
        queue_bin(1'b0, S_MAX, S_MAX, S_MIN, S_MIN);
        queue_bin(1'b0, S_MIN, S_MIN, S_MAX, S_MAX);
        queue_bin(1'b0, 24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA);
        queue_bin(1'b1, S_MAX, S_MAX, S_MAX, S_MAX);
        queue_bin(1'b1, S_MIN, S_MIN, S_MIN, S_MIN);

        // mostly whole frames with a few trailing bins, some cut short
        counted = 0;
        while (counted < ITEM_COUNT)
        begin
            broken = ($urandom_range(9) == 0);
            length = broken ? $urandom_range(1, FRAME_BINS - 1)
                            : FRAME_BINS + $urandom_range(0, 6);
            for (k = 0; k < length && counted < ITEM_COUNT; k++)
            begin
                queue_bin(k == 0, rand_sample(), rand_sample(), rand_sample(), rand_sample());
                if (k < FRAME_BINS)
                    counted++;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (bins_accepted < bins_total)
            @(posedge clk);
        while (expected_bands.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        while (cycle < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
